/* rtl/core/calendar_grid_day_lookup_unit_assert.svh */
// Assertion macros for the calendar grid day lookup unit.
// Used by the top level only; no other dependencies.
`ifndef CALENDAR_GRID_DAY_LOOKUP_UNIT_ASSERT_SVH
`define CALENDAR_GRID_DAY_LOOKUP_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CGDL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cgdl: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define CGDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cgdl: assertion failed");

`endif

/* rtl/core/cgdl_pkg.sv */
// Package for the calendar grid day lookup unit: word types, stage types,
// reciprocal constants and month tables. No dependencies.
package cgdl_pkg;

  // Calendar limits
  localparam int unsigned YearMin    = 1;
  localparam int unsigned YearMax    = 9999;
  localparam int unsigned YearSwitch = 1752;
  localparam int unsigned YearGreg   = 1800;
  localparam int unsigned CentBase   = 1700;
  localparam int unsigned QuadBase   = 1600;
  localparam int unsigned SwitchSkip = 11;
  localparam int unsigned SwitchSep  = 19;
  localparam int unsigned GridRows   = 6;
  localparam int unsigned GridCols   = 7;

  // floor(x/100) = (x * Div100Mul) >> Div100Shift for x below 8400
  localparam int unsigned Div100Mul   = 5243;
  localparam int unsigned Div100Shift = 19;
  // floor(x/7) = (x * Div7Mul) >> Div7Shift for x below 32768
  localparam int unsigned Div7Mul     = 18725;
  localparam int unsigned Div7Shift   = 17;

  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthDec = 4'd12;

  // Input word
  typedef struct packed {
    logic [13:0] year_number;
    logic [3:0]  month_number;
    logic [2:0]  week_row;
    logic [2:0]  weekday_column;
  } cgdl_in_t;

  // Result word
  typedef struct packed {
    logic [4:0] day_of_month;
    logic [4:0] month_length;
    logic [2:0] first_weekday;
    logic       leap_flag;
    logic       switch_year_flag;
    logic       invalid_flag;
  } cgdl_out_t;

  // Stage 1: quotients and raw flags
  typedef struct packed {
    logic [13:0] year;
    logic [12:0] quarter;    // (year + 3) / 4
    logic [7:0]  qa100;      // (year - 1700) / 100
    logic [7:0]  qb100;      // (year - 1701) / 100
    logic [4:0]  qa400;      // (year - 1600) / 400
    logic [4:0]  qb400;      // (year - 1601) / 400
    logic        late;       // year after the switch
    logic        sw;
    logic        div4;
    logic [3:0]  month;
    logic        inval;
    logic        cell_ok;
    logic [5:0]  rc;         // row * 7 + column
  } cgdl_s1_t;

  // Per-item control carried from stage 2 to the output
  typedef struct packed {
    logic [4:0] len;
    logic       leap;
    logic       sw;
    logic       inval;
    logic       sep;
    logic       cell_ok;
    logic [5:0] rc;
  } cgdl_ctl_t;

  // Days in a month of an ordinary year
  function automatic logic [4:0] base_days(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // Days before the first of a month in an ordinary year
  function automatic logic [8:0] base_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/calendar_grid_day_lookup_unit.sv */
// Top level of the calendar grid day lookup unit: six-stage pipeline.
// Depends on cgdl_pkg and calendar_grid_day_lookup_unit_assert.svh.
//
//  channel | signals                            | direction | word
//  --------+------------------------------------+-----------+-----------
//  input   | in_valid_i, in_ready_o, in_word_i  | in        | cgdl_in_t
//  result  | out_valid_o, out_ready_i, out_word_o| out      | cgdl_out_t
//
// One word can enter every cycle while the result side does not stall.
// The depth is set by the two reciprocal multiplies (year by 100 and 400,
// day count by 7), each followed by its own register. Each full stage holds
// while the stage after it is full and stalled, so a stall on the result
// side backs up stage by stage, filling bubbles first.
// Reset clears the stage valid bits only.
`include "calendar_grid_day_lookup_unit_assert.svh"

module calendar_grid_day_lookup_unit
  import cgdl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cgdl_in_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cgdl_out_t out_word_o
);

  // Stage valid bits and load enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_q || out_ready_i;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: range checks, year quotients by reciprocal multiply
  // ---------------------------------------------------------------
  cgdl_s1_t s1_d, s1_q;
  logic [13:0] yr;
  logic        ge_greg;
  logic [13:0] xa100, xb100, xa400, xb400;
  logic [26:0] pa100, pb100;
  logic [24:0] pa400, pb400;
  logic [14:0] yr_p3;
  logic [5:0]  row7;

  always_comb begin
    yr      = in_word_i.year_number;
    ge_greg = (yr >= 14'(YearGreg));
    // quotients only matter from 1800 on; keep operands at 0 below that
    xa100   = ge_greg ? (yr - 14'(CentBase))     : 14'd0;
    xb100   = ge_greg ? (yr - 14'(CentBase + 1)) : 14'd0;
    xa400   = ge_greg ? (yr - 14'(QuadBase))     : 14'd0;
    xb400   = ge_greg ? (yr - 14'(QuadBase + 1)) : 14'd0;
    pa100   = 27'(xa100) * 27'(Div100Mul);
    pb100   = 27'(xb100) * 27'(Div100Mul);
    // x / 400 is (x / 4) / 100
    pa400   = 25'(xa400[13:2]) * 25'(Div100Mul);
    pb400   = 25'(xb400[13:2]) * 25'(Div100Mul);
    yr_p3   = {1'b0, yr} + 15'd3;
    row7    = {in_word_i.week_row, 3'b000} - {3'b000, in_word_i.week_row};

    s1_d.year    = yr;
    s1_d.quarter = yr_p3[14:2];
    s1_d.qa100   = pa100[Div100Shift +: 8];
    s1_d.qb100   = pb100[Div100Shift +: 8];
    s1_d.qa400   = pa400[Div100Shift +: 5];
    s1_d.qb400   = pb400[Div100Shift +: 5];
    s1_d.late    = (yr > 14'(YearSwitch));
    s1_d.sw      = (yr == 14'(YearSwitch));
    s1_d.div4    = (yr[1:0] == 2'b00);
    s1_d.month   = in_word_i.month_number;
    s1_d.inval   = (yr < 14'(YearMin)) || (yr > 14'(YearMax)) ||
                   (in_word_i.month_number == 4'd0) ||
                   (in_word_i.month_number > MonthDec);
    s1_d.cell_ok = (in_word_i.week_row < 3'(GridRows)) &&
                   (in_word_i.weekday_column < 3'(GridCols));
    s1_d.rc      = row7 + {3'b000, in_word_i.weekday_column};
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
  end

  // ---------------------------------------------------------------
  // Stage 2: year type, month length and offset, January day count
  // ---------------------------------------------------------------
  cgdl_ctl_t   ctl2_d, ctl2_q;
  logic [14:0] ps2_d, ps2_q;
  logic [8:0]  off2_d, off2_q;
  logic        cent, quad;

  always_comb begin
    // a century year shows up as a step between the two quotients
    cent = (s1_q.qa100 != s1_q.qb100);
    quad = (s1_q.qa400 != s1_q.qb400);

    ctl2_d.leap    = s1_q.div4 && !(cent && !quad);
    ctl2_d.sw      = s1_q.sw;
    ctl2_d.inval   = s1_q.inval;
    ctl2_d.sep     = (s1_q.month == MonthSep);
    ctl2_d.cell_ok = s1_q.cell_ok;
    ctl2_d.rc      = s1_q.rc;

    if (s1_q.month == MonthFeb) begin
      ctl2_d.len = ctl2_d.leap ? 5'd29 : 5'd28;
    end else if (s1_q.month == MonthSep) begin
      ctl2_d.len = s1_q.sw ? 5'(SwitchSep) : 5'd30;
    end else begin
      ctl2_d.len = base_days(s1_q.month);
    end

    off2_d = base_start(s1_q.month);
    if (ctl2_d.leap && (s1_q.month > MonthFeb)) off2_d = off2_d + 9'd1;
    if (s1_q.sw && (s1_q.month > MonthSep)) off2_d = off2_d - 9'(SwitchSkip);

    // Julian count plus corrections: y + 4 + (y+3)/4 - c100 + c400 + shift
    ps2_d = {1'b0, s1_q.year} + 15'd4 + {2'b00, s1_q.quarter} +
            {10'd0, s1_q.qb400} + (s1_q.late ? 15'd3 : 15'd0) -
            {7'd0, s1_q.qb100};
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      ctl2_q <= ctl2_d;
      ps2_q  <= ps2_d;
      off2_q <= off2_d;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: day count of the first of the month
  // ---------------------------------------------------------------
  cgdl_ctl_t   ctl3_q;
  logic [14:0] d3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      ctl3_q <= ctl2_q;
      d3_q   <= ps2_q + {6'd0, off2_q};
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: quotient of the day count by 7
  // ---------------------------------------------------------------
  cgdl_ctl_t   ctl4_q;
  logic [14:0] d4_q;
  logic [12:0] q7_4_q;
  logic [29:0] p7;

  assign p7 = 30'(d3_q) * 30'(Div7Mul);

  always_ff @(posedge clk_i) begin
    if (en4) begin
      ctl4_q <= ctl3_q;
      d4_q   <= d3_q;
      q7_4_q <= p7[Div7Shift +: 13];
    end
  end

  // ---------------------------------------------------------------
  // Stage 5: weekday of the first of the month
  // ---------------------------------------------------------------
  cgdl_ctl_t   ctl5_q;
  logic [2:0]  dow5_q;
  logic [14:0] q7x7, rem7;

  always_comb begin
    q7x7 = {q7_4_q, 2'b00} + {1'b0, q7_4_q, 1'b0} + {2'b00, q7_4_q};
    rem7 = d4_q - q7x7;
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      ctl5_q <= ctl4_q;
      dow5_q <= rem7[2:0];
    end
  end

  // ---------------------------------------------------------------
  // Stage 6: grid cell date and result word
  // ---------------------------------------------------------------
  cgdl_out_t out6_d, out6_q;
  logic [5:0] dow6, t6, lim6;
  logic       in_month;

  always_comb begin
    dow6     = {3'b000, dow5_q};
    lim6     = {1'b0, ctl5_q.len} + dow6;
    in_month = ctl5_q.cell_ok && (ctl5_q.rc >= dow6) && (ctl5_q.rc < lim6);
    t6       = ctl5_q.rc - dow6 + 6'd1;
    // short September skips the eleven dates after the 2nd
    if (ctl5_q.sw && ctl5_q.sep && (t6 >= 6'd3)) t6 = t6 + 6'(SwitchSkip);

    out6_d.day_of_month     = in_month ? t6[4:0] : 5'd0;
    out6_d.month_length     = ctl5_q.len;
    out6_d.first_weekday    = dow5_q;
    out6_d.leap_flag        = ctl5_q.leap;
    out6_d.switch_year_flag = ctl5_q.sw;
    out6_d.invalid_flag     = 1'b0;
    if (ctl5_q.inval) begin
      out6_d              = '0;
      out6_d.invalid_flag = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) out6_q <= out6_d;
  end

  assign out_valid_o = v6_q;
  assign out_word_o  = out6_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `CGDL_ASSERT_IMPL(a_inval_zero, clk_i, rst_ni, out_valid_o && out_word_o.invalid_flag, out_word_o.day_of_month == 5'd0 && out_word_o.month_length == 5'd0)
  `CGDL_ASSERT_IMPL(a_switch_leap, clk_i, rst_ni, out_valid_o && out_word_o.switch_year_flag, out_word_o.leap_flag && !out_word_o.invalid_flag)
  `CGDL_ASSERT_IMPL(a_weekday_range, clk_i, rst_ni, out_valid_o, out_word_o.first_weekday <= 3'd6)
  `CGDL_ASSERT_NEXT(a_stage1_hold, clk_i, rst_ni, v1_q && !en2, v1_q)

endmodule

/* test/calendar_grid_day_lookup_unit_test.sv */
// Testbench for calendar_grid_day_lookup_unit: a directed table, then random lookups,
// checked against fixed table results or an in-bench calendar predictor. Both sides stall at random.
// Depends on cgdl_pkg and the calendar_grid_day_lookup_unit RTL.
module calendar_grid_day_lookup_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cgdl_pkg::*;

  localparam int NumRandom  = 700;
  localparam int NumDirect  = 26;
  localparam int CycleLimit = 200_000;
  localparam int DrainWait  = 40;
  localparam int HoldCycles = 250;
  localparam int HoldAt     = 200;

  // Only invalid_flag set: what every out-of-range year or month gives
  localparam cgdl_out_t InvalidResult = 16'h0001;
  localparam cgdl_out_t NoFixed       = 16'h0000;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        fixed;
    cgdl_out_t   want;
  } dir_row_t;

  typedef struct packed {
    cgdl_in_t  word;
    cgdl_out_t want;
  } awaited_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      word_valid = 1'b0;
  logic      word_ready;
  cgdl_in_t  word_in = '0;
  logic      cell_valid;
  logic      cell_ready = 1'b0;
  cgdl_out_t cell_word;

  awaited_t awaited_cells[$];
  int       fail_cnt = 0;
  int       cell_cnt = 0;
  int       cycle_cnt = 0;
  bit       hold_active = 1'b0;

  // Directed lookups: extremes, out-of-range codes, the short September, grid edges
  dir_row_t dir_table [NumDirect] = '{
    '{14'd1,     4'd1,  3'd0, 3'd0, 1'b0, NoFixed},
    '{14'd1,     4'd12, 3'd5, 3'd6, 1'b0, NoFixed},
    '{14'd9999,  4'd12, 3'd5, 3'd6, 1'b0, NoFixed},
    '{14'd9999,  4'd1,  3'd0, 3'd0, 1'b0, NoFixed},
    '{14'd0,     4'd1,  3'd0, 3'd0, 1'b1, InvalidResult},
    '{14'd10000, 4'd6,  3'd2, 3'd3, 1'b1, InvalidResult},
    '{14'd16383, 4'd15, 3'd7, 3'd7, 1'b1, InvalidResult},
    '{14'd2024,  4'd0,  3'd1, 3'd1, 1'b1, InvalidResult},
    '{14'd2024,  4'd13, 3'd1, 3'd1, 1'b1, InvalidResult},
    '{14'd9999,  4'd15, 3'd0, 3'd0, 1'b1, InvalidResult},
    '{14'd1752,  4'd9,  3'd0, 3'd1, 1'b0, NoFixed},
    '{14'd1752,  4'd9,  3'd0, 3'd2, 1'b0, NoFixed},
    '{14'd1752,  4'd9,  3'd0, 3'd3, 1'b0, NoFixed},
    '{14'd1752,  4'd9,  3'd0, 3'd4, 1'b0, NoFixed},
    '{14'd1752,  4'd9,  3'd2, 3'd6, 1'b0, NoFixed},
    '{14'd1752,  4'd9,  3'd3, 3'd0, 1'b0, NoFixed},
    '{14'd1752,  4'd2,  3'd4, 3'd2, 1'b0, NoFixed},
    '{14'd1752,  4'd12, 3'd5, 3'd0, 1'b0, NoFixed},
    '{14'd1753,  4'd1,  3'd0, 3'd0, 1'b0, NoFixed},
    '{14'd1800,  4'd2,  3'd4, 3'd3, 1'b0, NoFixed},
    '{14'd1801,  4'd1,  3'd0, 3'd0, 1'b0, NoFixed},
    '{14'd1900,  4'd2,  3'd4, 3'd0, 1'b0, NoFixed},
    '{14'd2000,  4'd2,  3'd4, 3'd2, 1'b0, NoFixed},
    '{14'd2024,  4'd3,  3'd6, 3'd0, 1'b0, NoFixed},
    '{14'd2024,  4'd3,  3'd7, 3'd7, 1'b0, NoFixed},
    '{14'd2024,  4'd3,  3'd0, 3'd7, 1'b0, NoFixed}
  };

  calendar_grid_day_lookup_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (word_valid),
    .in_ready_o  (word_ready),
    .in_word_i   (word_in),
    .out_valid_o (cell_valid),
    .out_ready_i (cell_ready),
    .out_word_o  (cell_word)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Weekday of January 1st, Sunday = 0, Julian count with late corrections
  function automatic int jan1_weekday(int y);
    int d;
    d = y + 4 + (y + 3) / 4;
    if (y > 1800) begin
      d -= (y - 1701) / 100;
      d += (y - 1601) / 400;
    end
    if (y > 1752) begin
      d += 3;
    end
    return d % 7;
  endfunction

  function automatic int month_days(int m, int feb_len, int sep_len);
    int r;
    if (m == int'(MonthFeb)) begin
      r = feb_len;
    end else if (m == int'(MonthSep)) begin
      r = sep_len;
    end else begin
      case (m)
        4, 6, 11: r = 30;
        default:  r = 31;
      endcase
    end
    return r;
  endfunction

  // Expected grid cell for one lookup word
  function automatic cgdl_out_t grid_cell_lookup(cgdl_in_t w);
    cgdl_out_t r;
    int year, month, row, col, dow, gap, feb_len, sep_len, len, t;
    bit short_sep;
    r = '0;
    year  = int'(w.year_number);
    month = int'(w.month_number);
    row   = int'(w.week_row);
    col   = int'(w.weekday_column);
    if (year < 1 || year > 9999 || month < 1 || month > int'(MonthDec)) begin
      r.invalid_flag = 1'b1;
      return r;
    end
    dow = jan1_weekday(year);
    gap = (jan1_weekday(year + 1) + 7 - dow) % 7;
    feb_len = 29;
    sep_len = 30;
    short_sep = 1'b0;
    // gap of one day: ordinary; two: leap; anything else: the switch year
    if (gap == 1) begin
      feb_len = 28;
    end else if (gap != 2) begin
      sep_len = 19;
      short_sep = 1'b1;
    end
    len = month_days(month, feb_len, sep_len);
    for (int m = 1; m < month; m++) begin
      dow += month_days(m, feb_len, sep_len);
    end
    dow %= 7;
    t = 0;
    if (row < 6 && col < 7) begin
      t = row * 7 + col - dow + 1;
      if (t < 1 || t > len) begin
        t = 0;
      end else if (short_sep && month == int'(MonthSep) && t >= 3) begin
        t += 11;  // dates 3 to 13 skipped
      end
    end
    r.day_of_month     = t[4:0];
    r.month_length     = len[4:0];
    r.first_weekday    = dow[2:0];
    r.leap_flag        = (feb_len == 29);
    r.switch_year_flag = short_sep;
    r.invalid_flag     = 1'b0;
    return r;
  endfunction

  // Random lookup: mostly in-range cells, with the switch year and noise mixed in
  function automatic cgdl_in_t random_lookup();
    cgdl_in_t w;
    int sel;
    sel = $urandom_range(0, 99);
    w.year_number    = 14'($urandom_range(1, 9999));
    w.month_number   = 4'($urandom_range(1, 12));
    w.week_row       = 3'($urandom_range(0, 5));
    w.weekday_column = 3'($urandom_range(0, 6));
    if (sel < 8) begin
      w.year_number  = 14'd1752;
      w.month_number = MonthSep;
    end else if (sel < 14) begin
      w.year_number = 14'($urandom_range(1751, 1753));
    end else if (sel < 20) begin
      // around century boundaries from 1700 to 9900
      w.year_number = 14'($urandom_range(17, 99) * 100 + $urandom_range(0, 2) - 1);
    end else if (sel < 28) begin
      w.year_number  = 14'($urandom_range(0, 16383));
      w.month_number = 4'($urandom_range(0, 15));
    end else if (sel < 31) begin
      w.year_number = 14'($urandom_range(10000, 16383));
    end else if (sel < 34) begin
      w.month_number = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
    end else if (sel < 42) begin
      w.week_row       = 3'($urandom_range(0, 7));
      w.weekday_column = 3'($urandom_range(0, 7));
    end
    return w;
  endfunction

  // Offer one word after an idle gap, hold it until taken, then log what it should give
  task automatic send_lookup(cgdl_in_t w, bit fixed, cgdl_out_t want, int gap);
    awaited_t a;
    if (gap > 0) begin
      word_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word_valid <= 1'b1;
    word_in    <= w;
    do @(posedge clk_i); while (!word_ready);
    a.word = w;
    a.want = fixed ? want : grid_cell_lookup(w);
    awaited_cells.push_back(a);
  endtask

  function automatic int sender_gap(int idx);
    int g;
    if (hold_active || (idx / 64) % 4 == 3) begin
      g = 0;
    end else begin
      g = $urandom_range(0, 15);
    end
    return g;
  endfunction

  task automatic check_field(string name, int want, int got, cgdl_in_t w);
    if (want != got) begin
      $display("%0t: %s mismatch for year %0d month %0d cell %0d/%0d: expected %0d actual %0d",
               $time, name, w.year_number, w.month_number, w.week_row, w.weekday_column,
               want, got);
      fail_cnt++;
    end
  endtask

  // Stimulus: reset, directed table, random lookups, drain
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumDirect; i++) begin
      send_lookup({dir_table[i].year, dir_table[i].month, dir_table[i].row, dir_table[i].col},
                  dir_table[i].fixed, dir_table[i].want, sender_gap(i));
    end
    for (int i = 0; i < NumRandom; i++) begin
      send_lookup(random_lookup(), 1'b0, NoFixed, sender_gap(i));
    end
    word_valid <= 1'b0;
    while (awaited_cells.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, field-by-field compare
  initial begin
    int stall;
    bit held;
    awaited_t a;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && cell_cnt == HoldAt) begin
        held = 1'b1;
        hold_active = 1'b1;
        stall = HoldCycles;
      end else if ((cell_cnt / 50) % 4 == 2) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 15);
      end
      if (stall > 0) begin
        cell_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      hold_active = 1'b0;
      cell_ready <= 1'b1;
      do @(posedge clk_i); while (!cell_valid);
      cell_cnt++;
      if (awaited_cells.size() == 0) begin
        $display("%0t: unexpected result: expected none actual %h", $time, cell_word);
        fail_cnt++;
      end else begin
        a = awaited_cells.pop_front();
        check_field("day_of_month", a.want.day_of_month, cell_word.day_of_month, a.word);
        check_field("month_length", a.want.month_length, cell_word.month_length, a.word);
        check_field("first_weekday", a.want.first_weekday, cell_word.first_weekday, a.word);
        check_field("leap_flag", a.want.leap_flag, cell_word.leap_flag, a.word);
        check_field("switch_year_flag", a.want.switch_year_flag, cell_word.switch_year_flag,
                    a.word);
        check_field("invalid_flag", a.want.invalid_flag, cell_word.invalid_flag, a.word);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, awaited_cells.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
